/* rtl/spcf_pkg.sv */
// spcf_pkg: shared types, constants and decimal digit helpers for the
// servo position command framer; no dependencies
`default_nettype none

package spcf_pkg;

  // register map and reset values
  localparam int unsigned CfgAddrW = 4;
  localparam logic [1:0] RegDefaultDur = 2'd0;
  localparam logic [1:0] RegMaxServoId = 2'd1;
  localparam logic [1:0] RegMinPulse   = 2'd2;
  localparam logic [1:0] RegMaxPulse   = 2'd3;

  localparam logic [13:0] DefaultDurRst = 14'd400;
  localparam logic [9:0]  MaxServoIdRst = 10'd999;
  localparam logic [13:0] MinPulseRst   = 14'd500;
  localparam logic [13:0] MaxPulseRst   = 14'd2500;

  localparam logic [9:0]  IdCap  = 10'd999;
  localparam logic [13:0] DurCap = 14'd9999;

  // frame layout: byte positions
  localparam logic [3:0] PosHash  = 4'd0;
  localparam logic [3:0] PosId2   = 4'd1;
  localparam logic [3:0] PosId1   = 4'd2;
  localparam logic [3:0] PosId0   = 4'd3;
  localparam logic [3:0] PosP     = 4'd4;
  localparam logic [3:0] PosPw3   = 4'd5;
  localparam logic [3:0] PosPw2   = 4'd6;
  localparam logic [3:0] PosPw1   = 4'd7;
  localparam logic [3:0] PosPw0   = 4'd8;
  localparam logic [3:0] PosT     = 4'd9;
  localparam logic [3:0] PosDu3   = 4'd10;
  localparam logic [3:0] PosDu2   = 4'd11;
  localparam logic [3:0] PosDu1   = 4'd12;
  localparam logic [3:0] PosDu0   = 4'd13;
  localparam logic [3:0] PosBang  = 4'd14;

  localparam logic [7:0] ChHash = 8'h23;
  localparam logic [7:0] ChP    = 8'h50;
  localparam logic [7:0] ChT    = 8'h54;
  localparam logic [7:0] ChBang = 8'h21;
  localparam logic [3:0] ChDigitHi = 4'h3;

  typedef struct packed {
    logic [13:0] default_dur;
    logic [9:0]  max_servo_id;
    logic [13:0] min_pulse;
    logic [13:0] max_pulse;
  } cfg_t;

  // checked command: reject flag with id, pulse width and clamped duration
  typedef struct packed {
    logic        rej;
    logic [9:0]  id;
    logic [13:0] pw;
    logic [13:0] dur;
  } chk_t;

  // decimal digits, index 0 is the units digit
  typedef struct packed {
    logic            rej;
    logic [2:0][3:0] id_d;
    logic [3:0][3:0] pw_d;
    logic [3:0][3:0] du_d;
  } bcd_t;

  // v / 1000 for v below 10000, by reciprocal multiply
  function automatic logic [3:0] q1000(input logic [13:0] v);
    logic [27:0] p;
    p = {14'd0, v} * 28'd8389;
    return p[26:23];
  endfunction

  function automatic logic [9:0] r1000(input logic [13:0] v, input logic [3:0] q);
    logic [13:0] t;
    t = v - ({10'd0, q} * 14'd1000);
    return t[9:0];
  endfunction

  // v / 100 for v below 1000
  function automatic logic [3:0] q100(input logic [9:0] v);
    logic [16:0] p;
    p = {7'd0, v} * 17'd41;
    return p[15:12];
  endfunction

  function automatic logic [6:0] r100(input logic [9:0] v, input logic [3:0] q);
    logic [9:0] t;
    t = v - ({6'd0, q} * 10'd100);
    return t[6:0];
  endfunction

  // v / 10 for v below 100
  function automatic logic [3:0] q10(input logic [6:0] v);
    logic [14:0] p;
    p = {8'd0, v} * 15'd205;
    return p[14:11];
  endfunction

  function automatic logic [3:0] r10(input logic [6:0] v, input logic [3:0] q);
    logic [6:0] t;
    t = v - ({3'd0, q} * 7'd10);
    return t[3:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/servo_position_command_framer_top.sv */
// servo position command framer: top level; commands pass the check, digit a,
// b, c and frame registers; one byte per cycle while the output is ready, 15
// a frame, one a rejection; the 4-stage front pipeline takes a command each
// cycle until full, so up to four commands queue behind the frame being sent
// reset is asynchronous active low: pipeline empties, registers take defaults
// depends on spcf_pkg, spcf_regs, spcf_check, spcf_digits, spcf_serial
`default_nettype none

module servo_position_command_framer_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration port
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [spcf_pkg::CfgAddrW-1:0]  paddr,
  input  wire logic [31:0]                    pwdata,
  output logic      [31:0]                    prdata,
  output logic                                pready,
  // command stream
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [39:0]                    s_axis_tdata,  // servo_id, pulse_width, duration
  // frame stream
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic      [7:0]                     m_axis_tdata,  // frame_byte
  output logic                                m_axis_tlast,
  output logic                                m_axis_tuser   // rejected
);
  import spcf_pkg::*;

  cfg_t cfg;
  chk_t chk_data;
  bcd_t bcd_data;
  logic chk_valid, chk_ready, bcd_valid, bcd_ready;

  spcf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  spcf_check u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .valid_i       (s_axis_tvalid),
    .ready_o       (s_axis_tready),
    .servo_id_i    (s_axis_tdata[10:0]),
    .pulse_width_i (s_axis_tdata[24:11]),
    .duration_i    (s_axis_tdata[39:25]),
    .valid_o       (chk_valid),
    .ready_i       (chk_ready),
    .data_o        (chk_data)
  );

  spcf_digits u_digits (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (chk_valid),
    .ready_o (chk_ready),
    .data_i  (chk_data),
    .valid_o (bcd_valid),
    .ready_i (bcd_ready),
    .data_o  (bcd_data)
  );

  spcf_serial u_serial (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (bcd_valid),
    .ready_o   (bcd_ready),
    .data_i    (bcd_data),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_byte_o  (m_axis_tdata),
    .m_last_o  (m_axis_tlast),
    .m_rej_o   (m_axis_tuser)
  );

endmodule

`default_nettype wire

/* rtl/spcf_regs.sv */
// spcf_regs: apb-style limit and default registers
// depends on spcf_pkg
`default_nettype none

module spcf_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [spcf_pkg::CfgAddrW-1:0]  paddr,
  input  wire logic [31:0]                    pwdata,
  output logic      [31:0]                    prdata,
  output logic                                pready,
  output spcf_pkg::cfg_t                      cfg_o
);
  import spcf_pkg::*;

  cfg_t cfg_q;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  // register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.default_dur  <= DefaultDurRst;
      cfg_q.max_servo_id <= MaxServoIdRst;
      cfg_q.min_pulse    <= MinPulseRst;
      cfg_q.max_pulse    <= MaxPulseRst;
    end else if (wr_en) begin
      case (paddr[3:2])
        RegDefaultDur: cfg_q.default_dur  <= pwdata[13:0];
        RegMaxServoId: cfg_q.max_servo_id <= pwdata[9:0];
        RegMinPulse:   cfg_q.min_pulse    <= pwdata[13:0];
        RegMaxPulse:   cfg_q.max_pulse    <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (paddr[3:2])
      RegDefaultDur: prdata = {18'd0, cfg_q.default_dur};
      RegMaxServoId: prdata = {22'd0, cfg_q.max_servo_id};
      RegMinPulse:   prdata = {18'd0, cfg_q.min_pulse};
      RegMaxPulse:   prdata = {18'd0, cfg_q.max_pulse};
      default:       prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/spcf_check.sv */
// spcf_check: first pipeline stage, range checks and duration select/clamp
// depends on spcf_pkg
`default_nettype none

module spcf_check (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire spcf_pkg::cfg_t  cfg_i,
  input  wire logic            valid_i,
  output logic                 ready_o,
  input  wire logic [10:0]     servo_id_i,
  input  wire logic [13:0]     pulse_width_i,
  input  wire logic [14:0]     duration_i,
  output logic                 valid_o,
  input  wire logic            ready_i,
  output spcf_pkg::chk_t       data_o
);
  import spcf_pkg::*;

  logic        valid_q;
  chk_t        data_q, data_d;
  logic [9:0]  id_lim;
  logic        id_ok, pw_ok;
  logic [13:0] dur_sel;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  // limit checks and duration handling
  always_comb begin
    id_lim  = (cfg_i.max_servo_id > IdCap) ? IdCap : cfg_i.max_servo_id;
    id_ok   = !servo_id_i[10] && (servo_id_i[9:0] <= id_lim);
    pw_ok   = !pulse_width_i[13] && (pulse_width_i >= cfg_i.min_pulse) &&
              (pulse_width_i <= cfg_i.max_pulse);
    dur_sel = (duration_i[14] || duration_i == 15'd0) ? cfg_i.default_dur
                                                       : duration_i[13:0];
    data_d.rej = !(id_ok && pw_ok);
    data_d.id  = servo_id_i[9:0];
    data_d.pw  = pulse_width_i;
    data_d.dur = (dur_sel > DurCap) ? DurCap : dur_sel;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/spcf_digits.sv */
// spcf_digits: three pipeline stages of binary to decimal digit extraction
// depends on spcf_pkg
`default_nettype none

module spcf_digits (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  output logic                 ready_o,
  input  wire spcf_pkg::chk_t  data_i,
  output logic                 valid_o,
  input  wire logic            ready_i,
  output spcf_pkg::bcd_t       data_o
);
  import spcf_pkg::*;

  logic       va_q, vb_q, vc_q;
  logic       en_a, en_b, en_c;
  bcd_t       da_q, db_q, dc_q;
  bcd_t       da_d, db_d, dc_d;
  logic [6:0] id_ra_q;
  logic [9:0] pw_ra_q, du_ra_q;
  logic [6:0] pw_rb_q, du_rb_q;
  logic [3:0] pw_th, du_th, id_h, id_t, pw_h, du_h, pw_t, du_t;

  assign en_c    = !vc_q || ready_i;
  assign en_b    = !vb_q || en_c;
  assign en_a    = !va_q || en_b;
  assign ready_o = en_a;
  assign valid_o = vc_q;
  assign data_o  = dc_q;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (en_a) va_q <= valid_i;
      if (en_b) vb_q <= va_q;
      if (en_c) vc_q <= vb_q;
    end
  end

  // stage a: thousands digits, id hundreds
  assign pw_th = q1000(data_i.pw);
  assign du_th = q1000(data_i.dur);
  assign id_h  = q100(data_i.id);

  always_comb begin
    da_d         = '0;
    da_d.rej     = data_i.rej;
    da_d.pw_d[3] = pw_th;
    da_d.du_d[3] = du_th;
    da_d.id_d[2] = id_h;
  end

  always_ff @(posedge clk_i) begin
    if (en_a && valid_i) begin
      da_q    <= da_d;
      pw_ra_q <= r1000(data_i.pw, pw_th);
      du_ra_q <= r1000(data_i.dur, du_th);
      id_ra_q <= r100(data_i.id, id_h);
    end
  end

  // stage b: hundreds digits, id tens and units
  assign pw_h = q100(pw_ra_q);
  assign du_h = q100(du_ra_q);
  assign id_t = q10(id_ra_q);

  always_comb begin
    db_d         = da_q;
    db_d.pw_d[2] = pw_h;
    db_d.du_d[2] = du_h;
    db_d.id_d[1] = id_t;
    db_d.id_d[0] = r10(id_ra_q, id_t);
  end

  always_ff @(posedge clk_i) begin
    if (en_b && va_q) begin
      db_q    <= db_d;
      pw_rb_q <= r100(pw_ra_q, pw_h);
      du_rb_q <= r100(du_ra_q, du_h);
    end
  end

  // stage c: tens and units digits
  assign pw_t = q10(pw_rb_q);
  assign du_t = q10(du_rb_q);

  always_comb begin
    dc_d         = db_q;
    dc_d.pw_d[1] = pw_t;
    dc_d.pw_d[0] = r10(pw_rb_q, pw_t);
    dc_d.du_d[1] = du_t;
    dc_d.du_d[0] = r10(du_rb_q, du_t);
  end

  always_ff @(posedge clk_i) begin
    if (en_c && vb_q) begin
      dc_q <= dc_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/spcf_serial.sv */
// spcf_serial: frame holding register and byte serialiser for the output stream
// depends on spcf_pkg
`default_nettype none

module spcf_serial (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  output logic                 ready_o,
  input  wire spcf_pkg::bcd_t  data_i,
  output logic                 m_valid_o,
  input  wire logic            m_ready_i,
  output logic [7:0]           m_byte_o,
  output logic                 m_last_o,
  output logic                 m_rej_o
);
  import spcf_pkg::*;

  logic       valid_q;
  logic [3:0] idx_q;
  bcd_t       frame_q;
  logic       last;
  logic [7:0] byte_sel;

  assign last      = frame_q.rej || (idx_q == PosBang);
  assign ready_o   = !valid_q || (m_ready_i && last);
  assign m_valid_o = valid_q;
  assign m_last_o  = last;
  assign m_rej_o   = frame_q.rej;
  assign m_byte_o  = frame_q.rej ? 8'd0 : byte_sel;

  // byte select by position
  always_comb begin
    case (idx_q)
      PosHash: byte_sel = ChHash;
      PosId2:  byte_sel = {ChDigitHi, frame_q.id_d[2]};
      PosId1:  byte_sel = {ChDigitHi, frame_q.id_d[1]};
      PosId0:  byte_sel = {ChDigitHi, frame_q.id_d[0]};
      PosP:    byte_sel = ChP;
      PosPw3:  byte_sel = {ChDigitHi, frame_q.pw_d[3]};
      PosPw2:  byte_sel = {ChDigitHi, frame_q.pw_d[2]};
      PosPw1:  byte_sel = {ChDigitHi, frame_q.pw_d[1]};
      PosPw0:  byte_sel = {ChDigitHi, frame_q.pw_d[0]};
      PosT:    byte_sel = ChT;
      PosDu3:  byte_sel = {ChDigitHi, frame_q.du_d[3]};
      PosDu2:  byte_sel = {ChDigitHi, frame_q.du_d[2]};
      PosDu1:  byte_sel = {ChDigitHi, frame_q.du_d[1]};
      PosDu0:  byte_sel = {ChDigitHi, frame_q.du_d[0]};
      PosBang: byte_sel = ChBang;
      default: byte_sel = 8'd0;
    endcase
  end

  // position counter and frame load
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= PosHash;
    end else if (ready_o) begin
      valid_q <= valid_i;
      idx_q   <= PosHash;
    end else if (m_ready_i) begin
      idx_q   <= idx_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      frame_q <= data_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/spcf_checker.sv */
// spcf_checker: port-level assertions on the frame stream, bound to the top level
// depends on servo_position_command_framer_top
`default_nettype none

module spcf_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic       m_axis_tlast,
  input wire logic       m_axis_tuser
);

  // a rejection is a single zero byte closing its command
  a_rej_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && m_axis_tdata == 8'd0)
    else $error("rejection result not a single zero byte");

  // a frame continues without gaps once started
  a_frame_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid && !m_axis_tuser)
    else $error("frame interrupted");

  // a new frame opens with the hash character
  a_frame_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=>
      !m_axis_tvalid || m_axis_tuser || m_axis_tdata == 8'h23)
    else $error("frame does not start with hash");

  // a frame ends with the exclamation mark
  a_frame_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast && !m_axis_tuser |-> m_axis_tdata == 8'h21)
    else $error("frame does not end with exclamation mark");

  // stalled transaction holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled output changed");

endmodule

bind servo_position_command_framer_top spcf_checker u_spcf_checker (.*);

`default_nettype wire

/* bench/servo_position_command_framer_top_tb.sv */
// servo_position_command_framer_top_tb: self-checking bench for the command framer,
// stream driver and monitor with bursty traffic and back-pressure, register writes over apb
// depends on spcf_pkg and servo_position_command_framer_top
`default_nettype none

module servo_position_command_framer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spcf_pkg::*;

  localparam int DrainCycles = 12;
  localparam int MaxReports  = 10;

  // one expected frame byte or rejection
  typedef struct packed {
    logic [7:0] fbyte;
    logic       last;
    logic       rej;
  } beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;  // servo_id [10:0], pulse_width [24:11], duration [39:25]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;       // frame_byte
  logic        m_axis_tlast;
  logic        m_axis_tuser;       // rejected

  // register shadow
  logic [13:0] shadow_default_dur = DefaultDurRst;
  logic [9:0]  shadow_max_id      = MaxServoIdRst;
  logic [13:0] shadow_min_pulse   = MinPulseRst;
  logic [13:0] shadow_max_pulse   = MaxPulseRst;

  logic [39:0] cmd_q[$];
  beat_t       frame_exp_q[$];

  int unsigned cmds_sent    = 0;
  int unsigned beats_seen   = 0;
  int unsigned rejects_seen = 0;
  int unsigned frames_seen  = 0;
  int unsigned mismatches   = 0;
  int unsigned settings_run = 0;
  int unsigned burst_left   = 0;
  int unsigned gap_left     = 0;
  int unsigned stall_mode   = 0;
  int unsigned mode_left    = 0;

  servo_position_command_framer_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [39:0] pack_cmd(input int id, input int pw, input int du);
    logic [10:0] id_f;
    logic [13:0] pw_f;
    logic [14:0] du_f;
    id_f = id[10:0];
    pw_f = pw[13:0];
    du_f = du[14:0];
    return {du_f, pw_f, id_f};
  endfunction

  // ascii digit k (0 = units) of v
  function automatic logic [7:0] ascii_digit(input int unsigned v, input int unsigned k);
    int unsigned p;
    p = 1;
    for (int i = 0; i < k; i++) p = p * 10;
    return 8'h30 + 8'((v / p) % 10);
  endfunction

  // works out the frame, or the rejection, for one accepted command
  task automatic queue_expected_frame(input logic [39:0] d);
    int id;
    int pw;
    int du;
    int unsigned id_lim;
    int unsigned dur;
    logic [7:0] fr[15];
    id = $signed(d[10:0]);
    pw = $signed(d[24:11]);
    du = $signed(d[39:25]);
    id_lim = (shadow_max_id > 10'd999) ? 999 : shadow_max_id;
    if (id < 0 || id > int'(id_lim) || pw < 0 || pw < int'(shadow_min_pulse) ||
        pw > int'(shadow_max_pulse)) begin
      frame_exp_q.push_back('{fbyte: 8'd0, last: 1'b1, rej: 1'b1});
    end else begin
      dur = (du <= 0) ? shadow_default_dur : du;
      if (dur > 9999) dur = 9999;
      fr[0]  = "#";
      fr[1]  = ascii_digit(id, 2);
      fr[2]  = ascii_digit(id, 1);
      fr[3]  = ascii_digit(id, 0);
      fr[4]  = "P";
      fr[5]  = ascii_digit(pw % 10000, 3);
      fr[6]  = ascii_digit(pw % 10000, 2);
      fr[7]  = ascii_digit(pw % 10000, 1);
      fr[8]  = ascii_digit(pw % 10000, 0);
      fr[9]  = "T";
      fr[10] = ascii_digit(dur, 3);
      fr[11] = ascii_digit(dur, 2);
      fr[12] = ascii_digit(dur, 1);
      fr[13] = ascii_digit(dur, 0);
      fr[14] = "!";
      for (int k = 0; k < 15; k++)
        frame_exp_q.push_back('{fbyte: fr[k], last: (k == 14), rej: 1'b0});
    end
  endtask

  // command source: bursts of random length separated by random gaps
  always @(posedge clk_i) begin : cmd_driver
    logic        nv;
    logic [39:0] nd;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      nv = s_axis_tvalid;
      nd = s_axis_tdata;
      if (s_axis_tvalid && s_axis_tready) begin
        queue_expected_frame(s_axis_tdata);
        cmds_sent++;
        nv = 1'b0;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
        end
      end
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_q.size() > 0) begin
          nd = cmd_q.pop_front();
          nv = 1'b1;
        end
      end
      s_axis_tvalid <= nv;
      s_axis_tdata  <= nd;
    end
  end

  // frame sink: stall pattern changes mode after a random run, checks each transaction
  always @(posedge clk_i) begin : frame_monitor
    beat_t got;
    beat_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{fbyte: m_axis_tdata, last: m_axis_tlast, rej: m_axis_tuser};
        beats_seen++;
        if (m_axis_tuser) rejects_seen++;
        else if (m_axis_tlast) frames_seen++;
        if (frame_exp_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("unexpected frame byte %h last %b rej %b", got.fbyte, got.last, got.rej);
        end else begin
          want = frame_exp_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= MaxReports)
              $display("mismatch: expected byte %h last %b rej %b, got byte %h last %b rej %b",
                       want.fbyte, want.last, want.rej, got.fbyte, got.last, got.rej);
          end
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 120);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= $urandom_range(0, 1);
        2: m_axis_tready <= (mode_left % 7) != 0;
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // apb write: setup then access; shadow follows at the write edge
  task automatic reg_write(input logic [1:0] idx, input int unsigned val);
    logic [31:0] junk;
    junk = $urandom;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    case (idx)
      RegMaxServoId: pwdata <= {junk[31:10], val[9:0]};
      default:       pwdata <= {junk[31:14], val[13:0]};
    endcase
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      RegDefaultDur: shadow_default_dur = val[13:0];
      RegMaxServoId: shadow_max_id      = val[9:0];
      RegMinPulse:   shadow_min_pulse   = val[13:0];
      default:       shadow_max_pulse   = val[13:0];
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_limits(input int unsigned dflt, input int unsigned max_id,
                            input int unsigned lo, input int unsigned hi);
    reg_write(RegDefaultDur, dflt);
    reg_write(RegMaxServoId, max_id);
    reg_write(RegMinPulse, lo);
    reg_write(RegMaxPulse, hi);
    settings_run++;
  endtask

  // wait for every command to be taken and every expected byte to arrive
  task automatic wait_drained();
    do @(negedge clk_i); while (cmd_q.size() != 0 || s_axis_tvalid || frame_exp_q.size() != 0);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // mostly in-range commands under the current limits, the rest unconstrained
  function automatic logic [39:0] random_cmd();
    int id;
    int pw;
    int du;
    int unsigned id_lim;
    int unsigned pw_hi;
    id_lim = (shadow_max_id > 10'd999) ? 999 : shadow_max_id;
    pw_hi  = (shadow_max_pulse > 14'd8191) ? 8191 : shadow_max_pulse;
    if ($urandom_range(0, 4) != 0 && shadow_min_pulse <= pw_hi) begin
      id = $urandom_range(0, id_lim);
      pw = $urandom_range(shadow_min_pulse, pw_hi);
    end else begin
      id = $signed(11'($urandom));
      pw = $signed(14'($urandom));
    end
    case ($urandom_range(0, 5))
      0:       du = 0;
      1:       du = -int'($urandom_range(1, 16384));
      2:       du = $urandom_range(10000, 16383);
      3:       du = $urandom_range(1, 9999);
      default: du = $signed(15'($urandom));
    endcase
    return pack_cmd(id, pw, du);
  endfunction

  task automatic random_burst(input int n);
    for (int i = 0; i < n; i++) cmd_q.push_back(random_cmd());
    wait_drained();
  endtask

  // stimulus sequence
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // reset limits: field extremes and limit edges
    cmd_q.push_back(pack_cmd(0, 500, 1));
    cmd_q.push_back(pack_cmd(999, 2500, 9999));
    cmd_q.push_back(pack_cmd(1000, 1500, 100));
    cmd_q.push_back(pack_cmd(-1, 1500, 100));
    cmd_q.push_back(pack_cmd(-1024, 1500, 100));
    cmd_q.push_back(pack_cmd(1023, 1500, 100));
    cmd_q.push_back(pack_cmd(12, 499, 100));
    cmd_q.push_back(pack_cmd(12, 2501, 100));
    cmd_q.push_back(pack_cmd(12, -8192, 100));
    cmd_q.push_back(pack_cmd(12, 8191, 100));
    cmd_q.push_back(pack_cmd(12, -1, 100));
    cmd_q.push_back(pack_cmd(345, 1234, 0));
    cmd_q.push_back(pack_cmd(345, 1234, -1));
    cmd_q.push_back(pack_cmd(345, 1234, -16384));
    cmd_q.push_back(pack_cmd(345, 1234, 16383));
    cmd_q.push_back(pack_cmd(345, 1234, 10000));
    cmd_q.push_back(pack_cmd(7, 2048, 1234));
    wait_drained();
    random_burst(50);

    // wide limits, id limit above three digits, zero default
    set_limits(0, 1023, 0, 9999);
    cmd_q.push_back(pack_cmd(1000, 0, 0));
    cmd_q.push_back(pack_cmd(999, 0, -5));
    cmd_q.push_back(pack_cmd(1023, 8191, 50));
    cmd_q.push_back(pack_cmd(0, 8191, 0));
    wait_drained();
    random_burst(35);

    // default above the clamp, single id, single pulse width
    set_limits(16383, 0, 1500, 1500);
    cmd_q.push_back(pack_cmd(0, 1500, 0));
    cmd_q.push_back(pack_cmd(1, 1500, 0));
    cmd_q.push_back(pack_cmd(0, 1499, 0));
    cmd_q.push_back(pack_cmd(0, 1501, 0));
    wait_drained();
    random_burst(25);

    // crossed pulse limits: everything rejected
    set_limits(9999, 500, 2000, 1000);
    random_burst(20);

    // random limit settings
    repeat (3) begin
      set_limits($urandom_range(0, 16383), $urandom_range(0, 1023),
                 $urandom_range(0, 4000), $urandom_range(2000, 16383));
      random_burst(20);
    end

    $display("covered %0d commands over %0d limit settings after reset", cmds_sent,
             settings_run);
    $display("checked %0d frame bytes: %0d full frames, %0d rejections", beats_seen,
             frames_seen, rejects_seen);
    if (mismatches == 0) begin
      $display("servo_position_command_framer_top test passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("servo_position_command_framer_top test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3000000;
    $display("timeout with %0d bytes still expected", frame_exp_q.size());
    $display("servo_position_command_framer_top test failed");
    $finish;
  end

endmodule

`default_nettype wire
